// ===== sv/bnms_pkg.sv =====
`default_nettype none

package bnms_pkg;

    localparam int FIELD_BITS = 12;
    localparam int SCORE_BITS = 16;
    localparam int THR_BITS   = 8;
    localparam int KEPT_BITS  = 6;
    localparam int ADDR_BITS  = 3;
    localparam int RESULT_CAP = 32;

    // register index, taken from paddr[2]
    localparam logic REG_IOU_THR  = 1'b0;
    localparam logic REG_MAX_KEPT = 1'b1;

    localparam logic [THR_BITS-1:0]  THR_RESET  = 8'd128;
    localparam logic [KEPT_BITS-1:0] KEPT_RESET = 6'd32;

    typedef struct packed {
        logic [FIELD_BITS-1:0]        box_x;
        logic [FIELD_BITS-1:0]        box_y;
        logic [FIELD_BITS-1:0]        box_w;
        logic [FIELD_BITS-1:0]        box_h;
        logic signed [SCORE_BITS-1:0] box_score;
        logic                         set_end;
    } t_in_beat;

    typedef struct packed {
        logic                         kept_valid;
        logic [FIELD_BITS-1:0]        out_x;
        logic [FIELD_BITS-1:0]        out_y;
        logic [FIELD_BITS-1:0]        out_w;
        logic [FIELD_BITS-1:0]        out_h;
        logic signed [SCORE_BITS-1:0] out_score;
        logic                         out_last;
        logic                         dropped_overflow;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_FLUSH,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic load_we;
        logic rd_en;
        logic clr;
        logic supp_en;
        logic pick;
        logic emit;
        logic emit_last;
        logic emit_empty;
        logic dropped;
    } t_dp_cmd;

    typedef struct packed {
        logic min_valid;
        logic pipe_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/bnms_dp.sv =====
`default_nettype none

module bnms_dp #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bnms_pkg::t_dp_cmd             i_cmd,
    input  wire logic [$clog2(MAX_BOXES)-1:0]  i_load_addr,
    input  wire logic [$clog2(MAX_BOXES)-1:0]  i_rd_addr,
    input  wire bnms_pkg::t_in_beat            i_box,
    input  wire logic [bnms_pkg::THR_BITS-1:0] i_thr,
    output bnms_pkg::t_dp_stat                 o_stat,
    output logic                               o_strobe,
    output bnms_pkg::t_out_beat                o_result
);

    localparam int IDXW = $clog2(MAX_BOXES);
    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 1;
    localparam int AW   = 2 * CB;
    localparam int UW   = AW + 1;
    localparam int PW   = UW + bnms_pkg::THR_BITS;

    typedef struct packed {
        logic [CB-1:0]                          x;
        logic [CB-1:0]                          y;
        logic [CB-1:0]                          w;
        logic [CB-1:0]                          h;
        logic signed [bnms_pkg::SCORE_BITS-1:0] score;
    } t_entry;

    t_entry r_mem [MAX_BOXES];

    t_entry        r_e1, r_e2, r_e3, r_e4, r_e5;
    logic [IDXW-1:0] r_idx1, r_idx2, r_idx3, r_idx4, r_idx5;
    logic [4:0]    r_v;
    logic [CB-1:0] r_dx, r_dy;
    logic [AW-1:0] r_inter3, r_area3, r_inter4, r_area4, r_area5;
    logic [UW-1:0] r_uni;
    logic [PW-1:0] r_prod;
    logic [AW+7:0] r_lhs;

    logic [MAX_BOXES-1:0] r_done;
    logic                 r_minv;
    logic [IDXW-1:0]      r_min_idx;
    t_entry               r_min;
    logic [AW-1:0]        r_min_area;
    t_entry               r_k;
    logic [AW-1:0]        r_ka;

    logic                r_strobe;
    bnms_pkg::t_out_beat r_res;

    t_entry        wr_entry;
    logic [EW-1:0] kx1, ky1, bx1, by1, x1, y1;
    logic [CB-1:0] x0, y0, dx, dy;
    logic          over;
    logic          better;

    always_comb begin
        wr_entry.x     = CB'(i_box.box_x);
        wr_entry.y     = CB'(i_box.box_y);
        wr_entry.w     = CB'(i_box.box_w);
        wr_entry.h     = CB'(i_box.box_h);
        wr_entry.score = i_box.box_score;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem[i_load_addr] <= wr_entry;
        end
        if (i_cmd.rd_en) begin
            r_e1   <= r_mem[i_rd_addr];
            r_idx1 <= i_rd_addr;
        end
    end

    // overlap extents against the current kept box
    always_comb begin
        kx1 = {1'b0, r_k.x} + {1'b0, r_k.w};
        ky1 = {1'b0, r_k.y} + {1'b0, r_k.h};
        bx1 = {1'b0, r_e1.x} + {1'b0, r_e1.w};
        by1 = {1'b0, r_e1.y} + {1'b0, r_e1.h};
        x0  = (r_k.x > r_e1.x) ? r_k.x : r_e1.x;
        y0  = (r_k.y > r_e1.y) ? r_k.y : r_e1.y;
        x1  = (kx1 < bx1) ? kx1 : bx1;
        y1  = (ky1 < by1) ? ky1 : by1;
        dx  = (x1 > {1'b0, x0}) ? CB'(x1 - {1'b0, x0}) : '0;
        dy  = (y1 > {1'b0, y0}) ? CB'(y1 - {1'b0, y0}) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_cmd.rd_en};
        end
        r_dx     <= dx;
        r_dy     <= dy;
        r_e2     <= r_e1;
        r_idx2   <= r_idx1;
        r_inter3 <= AW'(r_dx) * AW'(r_dy);
        r_area3  <= AW'(r_e2.w) * AW'(r_e2.h);
        r_e3     <= r_e2;
        r_idx3   <= r_idx2;
        r_uni    <= UW'(r_ka) + UW'(r_area3) - UW'(r_inter3);
        r_inter4 <= r_inter3;
        r_area4  <= r_area3;
        r_e4     <= r_e3;
        r_idx4   <= r_idx3;
        r_prod   <= PW'(i_thr) * PW'(r_uni);
        r_lhs    <= {r_inter4, 8'd0};
        r_area5  <= r_area4;
        r_e5     <= r_e4;
        r_idx5   <= r_idx4;
    end

    assign over   = i_cmd.supp_en && (PW'(r_lhs) > r_prod);
    assign better = !r_minv || ($signed(r_e5.score) < $signed(r_min.score));

    // strict compare in ascending index order keeps the earliest box on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_minv <= 1'b0;
        end else if (i_cmd.clr) begin
            r_done <= '0;
            r_minv <= 1'b0;
        end else if (i_cmd.pick) begin
            r_done[r_min_idx] <= 1'b1;
            r_minv            <= 1'b0;
            r_k               <= r_min;
            r_ka              <= r_min_area;
        end else if (r_v[4] && !r_done[r_idx5]) begin
            if (over) begin
                r_done[r_idx5] <= 1'b1;
            end else if (better) begin
                r_minv     <= 1'b1;
                r_min      <= r_e5;
                r_min_idx  <= r_idx5;
                r_min_area <= r_area5;
            end
        end
    end

    // r_k holds the box picked last; it goes out when the next pick or the end is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_res.kept_valid       <= !i_cmd.emit_empty;
            r_res.out_x            <= i_cmd.emit_empty ? '0 : bnms_pkg::FIELD_BITS'(r_k.x);
            r_res.out_y            <= i_cmd.emit_empty ? '0 : bnms_pkg::FIELD_BITS'(r_k.y);
            r_res.out_w            <= i_cmd.emit_empty ? '0 : bnms_pkg::FIELD_BITS'(r_k.w);
            r_res.out_h            <= i_cmd.emit_empty ? '0 : bnms_pkg::FIELD_BITS'(r_k.h);
            r_res.out_score        <= i_cmd.emit_empty ? '0 : r_k.score;
            r_res.out_last         <= i_cmd.emit_last;
            r_res.dropped_overflow <= i_cmd.dropped;
        end
    end

    assign o_stat.min_valid = r_minv;
    assign o_stat.pipe_busy = |r_v;
    assign o_strobe         = r_strobe;
    assign o_result         = r_res;

endmodule

`default_nettype wire

// ===== sv/bnms_ctrl.sv =====
`default_nettype none

module bnms_ctrl #(
    parameter int MAX_BOXES = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_set_end,
    input  wire logic [bnms_pkg::KEPT_BITS-1:0] i_limit,
    input  wire bnms_pkg::t_dp_stat             i_stat,
    output logic                                o_busy,
    output bnms_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(MAX_BOXES)-1:0]        o_load_addr,
    output logic [$clog2(MAX_BOXES)-1:0]        o_rd_addr
);

    localparam int IDXW = $clog2(MAX_BOXES);
    localparam int CW   = $clog2(MAX_BOXES + 1);

    bnms_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, r_addr, cnt_eff;
    logic             r_ovf, r_supp;
    logic [bnms_pkg::KEPT_BITS-1:0] r_kcnt, kc_next;
    logic             full, acc, scan_last;

    assign full      = (r_cnt == CW'(MAX_BOXES));
    assign acc       = i_start && (r_state == bnms_pkg::ST_IDLE);
    assign cnt_eff   = full ? r_cnt : r_cnt + CW'(1);
    assign scan_last = ((r_addr + CW'(1)) == r_cnt);
    assign kc_next   = r_kcnt + bnms_pkg::KEPT_BITS'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bnms_pkg::ST_IDLE: begin
                if (acc && i_set_end) begin
                    n_state = (cnt_eff == '0) ? bnms_pkg::ST_EMPTY : bnms_pkg::ST_SCAN;
                end
            end
            bnms_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = bnms_pkg::ST_DRAIN;
                end
            end
            bnms_pkg::ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = bnms_pkg::ST_PICK;
                end
            end
            bnms_pkg::ST_PICK: begin
                if (i_stat.min_valid && (kc_next != i_limit)) begin
                    n_state = bnms_pkg::ST_SCAN;
                end else begin
                    n_state = bnms_pkg::ST_FLUSH;
                end
            end
            bnms_pkg::ST_FLUSH: n_state = bnms_pkg::ST_IDLE;
            bnms_pkg::ST_EMPTY: n_state = bnms_pkg::ST_IDLE;
            default:            n_state = bnms_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.supp_en = r_supp;
        o_cmd.dropped = r_ovf;
        case (r_state)
            bnms_pkg::ST_IDLE: begin
                o_cmd.load_we = acc && !full;
                o_cmd.clr     = acc && i_set_end;
            end
            bnms_pkg::ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            bnms_pkg::ST_PICK: begin
                o_cmd.pick = i_stat.min_valid;
                o_cmd.emit = i_stat.min_valid && (r_kcnt != '0);
            end
            bnms_pkg::ST_FLUSH: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
            end
            bnms_pkg::ST_EMPTY: begin
                o_cmd.emit       = 1'b1;
                o_cmd.emit_last  = 1'b1;
                o_cmd.emit_empty = 1'b1;
            end
            default: begin
                o_cmd.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bnms_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_kcnt  <= '0;
            r_addr  <= '0;
            r_supp  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                bnms_pkg::ST_IDLE: begin
                    if (acc) begin
                        r_cnt <= cnt_eff;
                        r_ovf <= r_ovf | full;
                        if (i_set_end) begin
                            r_addr <= '0;
                            r_supp <= 1'b0;
                            r_kcnt <= '0;
                        end
                    end
                end
                bnms_pkg::ST_SCAN: begin
                    r_addr <= r_addr + CW'(1);
                end
                bnms_pkg::ST_PICK: begin
                    if (i_stat.min_valid) begin
                        r_kcnt <= kc_next;
                        r_addr <= '0;
                        r_supp <= 1'b1;
                    end
                end
                bnms_pkg::ST_FLUSH, bnms_pkg::ST_EMPTY: begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end
                default: begin
                    r_supp <= r_supp;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != bnms_pkg::ST_IDLE);
    assign o_load_addr = r_cnt[IDXW-1:0];
    assign o_rd_addr   = r_addr[IDXW-1:0];

endmodule

`default_nettype wire

// ===== sv/box_non_maximum_suppression.sv =====
// Channel   Handshake                         Beat
// input     start && !busy                    i_box    (t_in_beat)
// result    o_strobe, one cycle, no stall     o_result (t_out_beat)
// config    psel & penable & pwrite & pready  pwdata at paddr 0 / 4
//
// Loading takes one beat per cycle while busy is low. After the set_end beat,
// each pick scans all n held boxes through the single store read port plus a
// 5-stage overlap pipeline; once the set is done, start is taken again.
// Results leave one per pick; the receiver cannot stall them.
// Reset (synchronous, active low) empties the set and restores both registers.
`default_nettype none

module box_non_maximum_suppression #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire bnms_pkg::t_in_beat              i_box,
    output logic                                 o_strobe,
    output bnms_pkg::t_out_beat                  o_result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bnms_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [bnms_pkg::THR_BITS-1:0]  r_thr;
    logic [bnms_pkg::KEPT_BITS-1:0] r_kept, limit;
    logic                           wr_en;
    bnms_pkg::t_dp_cmd              cmd;
    bnms_pkg::t_dp_stat             stat;
    logic [$clog2(MAX_BOXES)-1:0]   load_addr, rd_addr;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= bnms_pkg::THR_RESET;
            r_kept <= bnms_pkg::KEPT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                bnms_pkg::REG_IOU_THR:  r_thr  <= pwdata[bnms_pkg::THR_BITS-1:0];
                bnms_pkg::REG_MAX_KEPT: r_kept <= pwdata[bnms_pkg::KEPT_BITS-1:0];
                default:                r_thr  <= r_thr;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bnms_pkg::REG_IOU_THR:  prdata = 32'(r_thr);
            bnms_pkg::REG_MAX_KEPT: prdata = 32'(r_kept);
            default:                prdata = '0;
        endcase
    end

    always_comb begin
        if (r_kept == '0) begin
            limit = bnms_pkg::KEPT_BITS'(1);
        end else if (r_kept > bnms_pkg::KEPT_BITS'(bnms_pkg::RESULT_CAP)) begin
            limit = bnms_pkg::KEPT_BITS'(bnms_pkg::RESULT_CAP);
        end else begin
            limit = r_kept;
        end
    end

    bnms_ctrl #(
        .MAX_BOXES (MAX_BOXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_set_end   (i_box.set_end),
        .i_limit     (limit),
        .i_stat      (stat),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_load_addr (load_addr),
        .o_rd_addr   (rd_addr)
    );

    bnms_dp #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_load_addr (load_addr),
        .i_rd_addr   (rd_addr),
        .i_box       (i_box),
        .i_thr       (r_thr),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a set in progress");

    a_no_result_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_box.set_end) |=> !o_strobe)
        else $error("result beat after a non-final input beat");

    a_last_ends_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.out_last) |=> !o_strobe)
        else $error("result beat right after the last one");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.kept_valid) |-> o_result.out_last)
        else $error("empty result not marked last");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;

    localparam int STORE_DEPTH = 32;
    localparam int IDLE_LIMIT  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    bnms_pkg::t_in_beat  i_box = '0;
    logic        o_strobe;
    bnms_pkg::t_out_beat o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [bnms_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_non_maximum_suppression dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_box(i_box), .o_strobe(o_strobe), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    bnms_pkg::t_in_beat held_boxes[STORE_DEPTH];
    int          held_count;
    bit          lost_any;
    logic [7:0]  thr_cfg;
    logic [5:0]  kept_cfg;

    bnms_pkg::t_in_beat  pending_boxes[$];
    bnms_pkg::t_out_beat kept_expect[$];
    int          err_count;
    int          idle_cycles = 0;
    int          send_idle_pct;
    bit          hold_send;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    task automatic add_expected(input bnms_pkg::t_out_beat r);
        kept_expect = {kept_expect, r};
    endtask

    task automatic add_pending(input bnms_pkg::t_in_beat b);
        pending_boxes = {pending_boxes, b};
    endtask

    function automatic bit too_much_overlap(input bnms_pkg::t_in_beat a,
                                            input bnms_pkg::t_in_beat b);
        longint unsigned x0, y0, x1, y1, inter, uni;
        x0 = (a.box_x > b.box_x) ? 64'(a.box_x) : 64'(b.box_x);
        y0 = (a.box_y > b.box_y) ? 64'(a.box_y) : 64'(b.box_y);
        x1 = ((64'(a.box_x) + 64'(a.box_w)) < (64'(b.box_x) + 64'(b.box_w))) ?
             64'(a.box_x) + 64'(a.box_w) : 64'(b.box_x) + 64'(b.box_w);
        y1 = ((64'(a.box_y) + 64'(a.box_h)) < (64'(b.box_y) + 64'(b.box_h))) ?
             64'(a.box_y) + 64'(a.box_h) : 64'(b.box_y) + 64'(b.box_h);
        inter = 0;
        if (x1 > x0 && y1 > y0) inter = (x1 - x0) * (y1 - y0);
        uni = 64'(a.box_w) * 64'(a.box_h) + 64'(b.box_w) * 64'(b.box_h) - inter;
        return inter * 256 > 64'(thr_cfg) * uni;
    endfunction

    task automatic predict_kept(input bnms_pkg::t_in_beat bx);
        int order[STORE_DEPTH];
        bit gone[STORE_DEPTH];
        int n, k, lim, emitted;
        bit ovf;
        bnms_pkg::t_out_beat r;
        if (held_count < STORE_DEPTH) begin
            held_boxes[held_count] = bx;
            held_count++;
        end else begin
            lost_any = 1'b1;
        end
        if (!bx.set_end) return;
        n = held_count;
        ovf = lost_any;
        held_count = 0;
        lost_any = 1'b0;
        if (n == 0) begin
            r = '0;
            r.out_last = 1'b1;
            r.dropped_overflow = ovf;
            add_expected(r);
            return;
        end
        for (int i = 0; i < n; i++) begin
            k = i;
            while (k > 0 && held_boxes[order[k-1]].box_score > held_boxes[i].box_score) begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
            gone[i] = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (gone[order[i]]) continue;
            for (int j = i + 1; j < n; j++)
                if (!gone[order[j]] &&
                    too_much_overlap(held_boxes[order[i]], held_boxes[order[j]]))
                    gone[order[j]] = 1'b1;
        end
        lim = (kept_cfg == 0) ? 1 : ((kept_cfg > 32) ? 32 : int'(kept_cfg));
        emitted = 0;
        for (int i = 0; i < n && emitted < lim; i++) begin
            if (gone[order[i]]) continue;
            r.kept_valid = 1'b1;
            r.out_x = held_boxes[order[i]].box_x;
            r.out_y = held_boxes[order[i]].box_y;
            r.out_w = held_boxes[order[i]].box_w;
            r.out_h = held_boxes[order[i]].box_h;
            r.out_score = held_boxes[order[i]].box_score;
            r.out_last = 1'b0;
            r.dropped_overflow = ovf;
            add_expected(r);
            emitted++;
        end
        kept_expect[kept_expect.size()-1].out_last = 1'b1;
    endtask

    // driver: start stays high across back-to-back beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_kept(i_box);
                void'(pending_boxes.pop_front());
            end
            if ((!start || !busy) && !hold_send) begin
                if (pending_boxes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    start <= 1'b1;
                    i_box <= pending_boxes[0];
                end else begin
                    start <= 1'b0;
                end
            end else if (hold_send && !(start && busy)) begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        bnms_pkg::t_out_beat want;
        if (i_rst_n && o_strobe) begin
            if (kept_expect.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = kept_expect.pop_front();
                if (o_result.kept_valid !== want.kept_valid)
                    report_mismatch($sformatf("kept_valid %b want %b",
                        o_result.kept_valid, want.kept_valid));
                if (o_result.out_x !== want.out_x)
                    report_mismatch($sformatf("out_x %0d want %0d", o_result.out_x, want.out_x));
                if (o_result.out_y !== want.out_y)
                    report_mismatch($sformatf("out_y %0d want %0d", o_result.out_y, want.out_y));
                if (o_result.out_w !== want.out_w)
                    report_mismatch($sformatf("out_w %0d want %0d", o_result.out_w, want.out_w));
                if (o_result.out_h !== want.out_h)
                    report_mismatch($sformatf("out_h %0d want %0d", o_result.out_h, want.out_h));
                if (o_result.out_score !== want.out_score)
                    report_mismatch($sformatf("out_score %0d want %0d",
                        o_result.out_score, want.out_score));
                if (o_result.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last %b want %b",
                        o_result.out_last, want.out_last));
                if (o_result.dropped_overflow !== want.dropped_overflow)
                    report_mismatch($sformatf("dropped_overflow %b want %b",
                        o_result.dropped_overflow, want.dropped_overflow));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL box_non_maximum_suppression");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == bnms_pkg::REG_IOU_THR) thr_cfg = val[7:0];
        else kept_cfg = val[5:0];
    endtask

    task automatic wait_drained();
        while (pending_boxes.size() > 0 || start || kept_expect.size() > 0)
            @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    function automatic bnms_pkg::t_in_beat rand_box(input bit last);
        bnms_pkg::t_in_beat b;
        b.box_x = 12'($urandom_range(4095));
        b.box_y = 12'($urandom_range(4095));
        b.box_w = 12'($urandom_range(4095));
        b.box_h = 12'($urandom_range(4095));
        b.box_score = 16'($urandom);
        b.set_end = last;
        return b;
    endfunction

    // clustered boxes so suppression actually happens
    function automatic bnms_pkg::t_in_beat near_box(input bit last);
        bnms_pkg::t_in_beat b;
        b.box_x = 12'(2000 + $urandom_range(60));
        b.box_y = 12'(1000 + $urandom_range(60));
        b.box_w = 12'(40 + $urandom_range(80));
        b.box_h = 12'(40 + $urandom_range(80));
        b.box_score = 16'($urandom_range(40) - 20);
        b.set_end = last;
        return b;
    endfunction

    function automatic bnms_pkg::t_in_beat mk_box(input int x, y, w, h, s, input bit last);
        bnms_pkg::t_in_beat b;
        b.box_x = 12'(x); b.box_y = 12'(y); b.box_w = 12'(w); b.box_h = 12'(h);
        b.box_score = 16'(s); b.set_end = last;
        return b;
    endfunction

    task automatic queue_set(input int n, input bit clustered);
        for (int i = 0; i < n; i++)
            add_pending(clustered ? near_box(i == n - 1) : rand_box(i == n - 1));
    endtask

    initial begin
        int n;
        held_count = 0; lost_any = 1'b0;
        thr_cfg = bnms_pkg::THR_RESET; kept_cfg = bnms_pkg::KEPT_RESET;
        err_count = 0;
        send_idle_pct = 0; hold_send = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, ties, zero areas, overflow on the end beat
        add_pending(mk_box(0, 0, 0, 0, 0, 1'b0));
        add_pending(mk_box(0, 0, 0, 0, 0, 1'b1));
        add_pending(mk_box(4095, 4095, 4095, 4095, 32767, 1'b0));
        add_pending(mk_box(4095, 4095, 4095, 4095, -32768, 1'b0));
        add_pending(mk_box(10, 10, 100, 100, 5, 1'b0));
        add_pending(mk_box(10, 10, 100, 100, 5, 1'b0));
        add_pending(mk_box(20, 20, 100, 100, -1, 1'b1));
        for (int i = 0; i < 34; i++)
            add_pending(near_box(i == 33));
        wait_drained();

        // pause the sender with a set queued, then let it go on
        hold_send = 1'b1;
        queue_set(5, 1'b1);
        repeat (50) @(posedge i_clk);
        hold_send = 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(bnms_pkg::REG_IOU_THR, 32'd0);
                         write_reg(bnms_pkg::REG_MAX_KEPT, 32'd1); end
                1: begin write_reg(bnms_pkg::REG_IOU_THR, 32'd255);
                         write_reg(bnms_pkg::REG_MAX_KEPT, 32'd32); end
                2: begin write_reg(bnms_pkg::REG_IOU_THR, $urandom_range(255));
                         write_reg(bnms_pkg::REG_MAX_KEPT, 32'd0); end
                default: begin write_reg(bnms_pkg::REG_IOU_THR, 32'd128);
                               write_reg(bnms_pkg::REG_MAX_KEPT, $urandom_range(63)); end
            endcase
            send_idle_pct = (ph == 1) ? 72 : ((ph == 2) ? 10 : 0);
            for (int s = 0; s < 9; s++) begin
                n = ($urandom_range(9) == 0) ? 36 : $urandom_range(1, 8);
                queue_set(n, $urandom_range(3) != 0);
            end
            wait_drained();
        end

        if (err_count == 0) begin
            $display("PASS box_non_maximum_suppression");
        end else begin
            $display("FAIL box_non_maximum_suppression");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
sv/bnms_pkg.sv
sv/bnms_dp.sv
sv/bnms_ctrl.sv
sv/box_non_maximum_suppression.sv
bench/testbench.sv
